// ===== rtl/me2usb_pkg.sv =====
// Shared types and constants for the MIDI event to USB-MIDI packet encoder.
// No dependencies; imported by every module of the block.
package me2usb_pkg;

  // MIDI status bytes with special handling.
  localparam logic [7:0] MIDI_SOX = 8'hF0;
  localparam logic [7:0] MIDI_EOX = 8'hF7;
  localparam logic [7:0] MIDI_MTC = 8'hF1;
  localparam logic [7:0] MIDI_SPP = 8'hF2;
  localparam logic [7:0] MIDI_SSEL = 8'hF3;

  // USB-MIDI code index numbers.
  localparam logic [3:0] CIN_COMMON2 = 4'd2;
  localparam logic [3:0] CIN_COMMON3 = 4'd3;
  localparam logic [3:0] CIN_SYSEX = 4'd4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'd5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'd6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'd7;

  // One input word: packed event with its timestamp.
  typedef struct packed {
    logic [31:0] event_message;
    logic [31:0] event_time;
  } event_t;

  // One result word: a USB-MIDI event packet.
  typedef struct packed {
    logic [3:0]  packet_cable;
    logic [3:0]  code_index;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
    logic [31:0] packet_time;
    logic        last_of_run;
  } packet_t;

endpackage

// ===== rtl/midi_event_to_usb_packet.sv =====
// MIDI event to USB-MIDI event packet encoder: one input word register, the
// combinational encoder and a two-entry result queue. Depends on me2usb_pkg, me2usb_encode.
//
// Each accepted event becomes zero, one or two 4-byte USB-MIDI packets, shown
// one per cycle, while out_stall is low, on the out_ channel in order; the
// last one carries last_of_run. An event is taken into an input register and
// encoded from there once the two-entry result queue has room for all of its
// packets. Events yielding one packet flow at one per cycle when the output is
// not stalled; an event yielding two packets holds the output longer, set by the
// single output port of the result queue. Sysex bytes are repacked three at a
// time through a two-byte holding buffer that persists between events. The
// cable number register is written through cfg_ (always ready); the user must
// write it only while the block is idle, as the block itself does not check it.
module midi_event_to_usb_packet (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  me2usb_pkg::event_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output me2usb_pkg::packet_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  import me2usb_pkg::*;

  logic            ivalid_r;
  logic            ivalid_nxt;
  event_t          item_r;
  logic [3:0]      cable_r;
  logic [1:0][7:0] hold_r;
  logic [1:0]      count_r;
  packet_t         q0_r;
  packet_t         q0_nxt;
  packet_t         q1_r;
  packet_t         q1_nxt;
  logic [1:0]      occ_r;
  logic [1:0]      occ_nxt;

  logic [1:0]      num_pkts;
  packet_t         pkt0;
  packet_t         pkt1;
  logic [1:0][7:0] hold_nxt;
  logic [1:0]      count_nxt;

  logic            pop;
  logic [1:0]      occ_p;
  logic            fits;
  logic            process;
  logic            in_accept;

  me2usb_encode u_encode (
    .item      (item_r),
    .cable     (cable_r),
    .hold      (hold_r),
    .count     (count_r),
    .num_pkts  (num_pkts),
    .pkt0      (pkt0),
    .pkt1      (pkt1),
    .hold_nxt  (hold_nxt),
    .count_nxt (count_nxt)
  );

  // Handshake and queue room.
  assign pop       = out_valid & ~out_stall;
  assign occ_p     = occ_r - {1'b0, pop};
  assign fits      = ({1'b0, occ_p} + {1'b0, num_pkts}) <= 3'd2;
  assign process   = ivalid_r & fits;
  assign in_stall  = ivalid_r & ~fits;
  assign in_accept = in_valid & ~in_stall;
  assign ivalid_nxt = in_accept | (ivalid_r & ~process);
  assign cfg_ready = 1'b1;
  assign out_valid = occ_r != 2'd0;
  assign out_word  = q0_r;

  // Result queue: shift out on pop, then append the new packets.
  always_comb begin
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    if (pop) q0_nxt = q1_r;
    occ_nxt = occ_p;
    if (process) begin
      if (occ_p == 2'd0) begin
        if (num_pkts != 2'd0) q0_nxt = pkt0;
        if (num_pkts == 2'd2) q1_nxt = pkt1;
      end else if (num_pkts != 2'd0) begin
        q1_nxt = pkt0;
      end
      occ_nxt = occ_p + num_pkts;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
      occ_r    <= 2'd0;
      count_r  <= 2'd0;
      cable_r  <= 4'd0;
    end else begin
      ivalid_r <= ivalid_nxt;
      occ_r    <= occ_nxt;
      if (process) count_r <= count_nxt;
      if (cfg_valid && cfg_ready) cable_r <= cfg_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) item_r <= in_word;
    if (process) hold_r <= hold_nxt;
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

// ===== rtl/me2usb_encode.sv =====
// Combinational encoder: turns one MIDI event and the sysex holding state into
// up to two USB-MIDI packets and the next holding state. Depends on me2usb_pkg.
module me2usb_encode (
  input  me2usb_pkg::event_t  item,
  input  logic [3:0]          cable,
  input  logic [1:0][7:0]     hold,
  input  logic [1:0]          count,
  output logic [1:0]          num_pkts,
  output me2usb_pkg::packet_t pkt0,
  output me2usb_pkg::packet_t pkt1,
  output logic [1:0][7:0]     hold_nxt,
  output logic [1:0]          count_nxt
);
  import me2usb_pkg::*;

  function automatic packet_t make_pkt(logic [3:0] cbl, logic [3:0] cin, logic [7:0] b1,
                                       logic [7:0] b2, logic [7:0] b3, logic [31:0] t);
    packet_t p;
    p.packet_cable = cbl;
    p.code_index   = cin;
    p.first_byte   = b1;
    p.second_byte  = b2;
    p.third_byte   = b3;
    p.packet_time  = t;
    p.last_of_run  = 1'b0;
    return p;
  endfunction

  logic [7:0]      st;
  logic [7:0]      d1;
  logic [7:0]      d2;
  logic [7:0]      b;
  logic [1:0]      cnt;
  logic [1:0][7:0] h;
  logic            done;
  packet_t         pk;
  logic [1:0]      n;

  always_comb begin
    st = item.event_message[7:0];
    d1 = item.event_message[15:8];
    d2 = item.event_message[23:16];
    b = '0;
    cnt = count;
    h = hold;
    done = 1'b0;
    pk = '0;
    n = 2'd0;
    pkt0 = '0;
    pkt1 = '0;
    hold_nxt = hold;
    count_nxt = count;

    if (!st[7] || st == MIDI_SOX || st == MIDI_EOX) begin
      // Sysex path: scan the four bytes in order through the holding buffer.
      for (int i = 0; i < 4; i++) begin
        b = item.event_message[8*i +: 8];
        if (!done) begin
          if (b == MIDI_EOX) begin
            unique case (cnt)
              2'd0:    pk = make_pkt(cable, CIN_SYSEX_END1, b, 8'h00, 8'h00, 32'h0);
              2'd1:    pk = make_pkt(cable, CIN_SYSEX_END2, h[0], b, 8'h00, 32'h0);
              default: pk = make_pkt(cable, CIN_SYSEX_END3, h[0], h[1], b, 32'h0);
            endcase
            if (n == 2'd0) pkt0 = pk;
            else pkt1 = pk;
            n = n + 2'd1;
            cnt = 2'd0;
            done = 1'b1;
          end else if (cnt >= 2'd2) begin
            pk = make_pkt(cable, CIN_SYSEX, h[0], h[1], b, 32'h0);
            if (n == 2'd0) pkt0 = pk;
            else pkt1 = pk;
            n = n + 2'd1;
            cnt = 2'd0;
          end else begin
            h[cnt[0]] = b;
            cnt = cnt + 2'd1;
          end
        end
      end
      hold_nxt = h;
      count_nxt = cnt;
    end else if (st == MIDI_MTC || st == MIDI_SSEL) begin
      pkt0 = make_pkt(cable, CIN_COMMON2, st, d1, d2, item.event_time);
      n = 2'd1;
    end else if (st == MIDI_SPP) begin
      pkt0 = make_pkt(cable, CIN_COMMON3, st, d1, d2, item.event_time);
      n = 2'd1;
    end else begin
      pkt0 = make_pkt(cable, st[7:4], st, d1, d2, item.event_time);
      n = 2'd1;
    end

    // Mark the final packet of this event.
    if (n == 2'd1) pkt0.last_of_run = 1'b1;
    if (n == 2'd2) pkt1.last_of_run = 1'b1;
    num_pkts = n;
  end

endmodule

// ===== rtl/me2usb_checker.sv =====
// Port-level checker for midi_event_to_usb_packet, bound to the top level.
// Depends on me2usb_pkg.
module me2usb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input me2usb_pkg::packet_t out_word
);
  import me2usb_pkg::*;

  // A stalled result word stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word dropped or changed");

  // Code index 0 and 1 are never produced.
  a_cin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.code_index != 4'd0 && out_word.code_index != 4'd1)
    else $error("reserved code index emitted");

  // Sysex packets carry no timestamp.
  a_sysex_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.code_index == CIN_SYSEX || out_word.code_index == CIN_SYSEX_END1
      || out_word.code_index == CIN_SYSEX_END2 || out_word.code_index == CIN_SYSEX_END3)
    |-> out_word.packet_time == 32'h0)
    else $error("sysex packet with nonzero time");

  // A lone terminator packet is F7 followed by zero pad.
  a_end1_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.code_index == CIN_SYSEX_END1
    |-> out_word.first_byte == MIDI_EOX && out_word.second_byte == 8'h00
      && out_word.third_byte == 8'h00)
    else $error("malformed single-byte sysex end packet");

endmodule

bind midi_event_to_usb_packet me2usb_checker u_me2usb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
